// ----- hw/rtl/rcm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared widths, codes, record types and helpers of the raycast column
// texel mapper.
// ----------------------------------------------------------------------------
package rcm_pkg;

    localparam int BLOCK           = 64;
    localparam int BYTES_PER_PIXEL = 4;

    // field widths
    localparam int COL_W   = 12;
    localparam int ROW_W   = 12;
    localparam int HQ_W    = 24;
    localparam int TSEL_W  = 2;
    localparam int BOFF_W  = 8;
    localparam int SRC_W   = 2;
    localparam int COLOR_W = 32;
    localparam int DIM_W   = 13;
    localparam int LL_W    = 16;
    localparam int TEX_W   = 12;
    localparam int OFF_W   = 32;

    // derived arithmetic widths
    localparam int FRAC_W   = 8;
    localparam int SCRQ_W   = DIM_W + FRAC_W;
    localparam int START_W  = SCRQ_W - FRAC_W - 1;
    localparam int HINT_W   = HQ_W - FRAC_W;
    localparam int END_W    = HINT_W + 1;
    localparam int POS_W    = HQ_W + 1;
    localparam int DEN_W    = HQ_W + 1;
    localparam int NUM_W    = DIM_W + POS_W;
    localparam int QUO_W    = 14;
    localparam int FACT_W   = DIM_W - $clog2(BLOCK);
    localparam int TCOLR_W  = BOFF_W + FACT_W;
    localparam int PROD_W   = ROW_W + LL_W;

    // configuration port
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int APB_W     = 32;

    localparam logic [REG_IDX_W-1:0] REG_CEIL_COLOR  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FLOOR_COLOR = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCR_H       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TEX_W       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TEX_H       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LINE_LEN    = 3'd5;

    localparam logic [DIM_W-1:0] SCR_H_RST    = 13'd480;
    localparam logic [DIM_W-1:0] TEX_W_RST    = 13'd64;
    localparam logic [DIM_W-1:0] TEX_H_RST    = 13'd64;
    localparam logic [LL_W-1:0]  LINE_LEN_RST = 16'd2560;

    // pixel source codes
    localparam logic [SRC_W-1:0] SRC_CEIL  = 2'd0;
    localparam logic [SRC_W-1:0] SRC_WALL  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_FLOOR = 2'd2;

    typedef struct packed {
        logic [COLOR_W-1:0] ceil_color;
        logic [COLOR_W-1:0] floor_color;
        logic [DIM_W-1:0]   scr_h;
        logic [DIM_W-1:0]   tex_w;
        logic [DIM_W-1:0]   tex_h;
        logic [LL_W-1:0]    line_len;
    } t_cfg;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [HQ_W-1:0]   wall_height;
        logic [TSEL_W-1:0] tsel;
        logic [BOFF_W-1:0] boff;
    } t_pix;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [HQ_W-1:0]    hq;
        logic [START_W-1:0] start;
        logic [HINT_W-1:0]  hint;
        logic [HQ_W-1:0]    clip2;
        logic [TSEL_W-1:0]  tsel;
        logic [BOFF_W-1:0]  boff;
    } t_geo;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [HQ_W-1:0]   hq;
        logic [POS_W-1:0]  pos;
        logic [SRC_W-1:0]  src;
        logic [TSEL_W-1:0] tsel;
        logic [BOFF_W-1:0] boff;
    } t_cls;

    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [HQ_W-1:0]    hq;
        logic [SRC_W-1:0]   src;
        logic [TSEL_W-1:0]  tsel;
        logic [TCOLR_W-1:0] tcol_raw;
        logic [OFF_W-1:0]   poff;
    } t_prod;

    typedef struct packed {
        logic [SRC_W-1:0]   src;
        logic [COLOR_W-1:0] flat;
        logic [TSEL_W-1:0]  tidx;
        logic [TEX_W-1:0]   tcol;
        logic [OFF_W-1:0]   poff;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        t_side            side;
    } t_dvin;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] den;
        t_side            side;
    } t_dstep;

    typedef struct packed {
        logic [SRC_W-1:0]   src;
        logic [COLOR_W-1:0] flat;
        logic [TSEL_W-1:0]  tidx;
        logic [TEX_W-1:0]   tcol;
        logic [TEX_W-1:0]   trow;
        logic [OFF_W-1:0]   poff;
    } t_res;

    // a texture size of zero behaves as one
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        eff_dim = (d == '0) ? DIM_W'(1) : d;
    endfunction

endpackage

// ----- hw/rtl/rcm_classify.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_classify
// Two pipeline stages: wall span on screen, then ceiling / wall / floor
// decision and the Q.9 position of the row inside the slice.
// ----------------------------------------------------------------------------
module rcm_classify (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rcm_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  rcm_pkg::t_pix  i_pix,
    output logic           o_valid,
    input  logic           i_ready,
    output rcm_pkg::t_cls  o_cls
);

    logic                                r_a_vld;
    rcm_pkg::t_geo                       r_geo;
    rcm_pkg::t_geo                       n_geo;
    logic                                r_b_vld;
    rcm_pkg::t_cls                       r_cls;
    rcm_pkg::t_cls                       n_cls;
    logic                                w_adv_a;
    logic                                w_adv_b;
    logic [rcm_pkg::HQ_W-1:0]            w_hq;
    logic [rcm_pkg::HQ_W-1:0]            w_scr_q;
    logic [rcm_pkg::HQ_W-1:0]            w_diff;
    logic [rcm_pkg::HQ_W-1:0]            w_over;
    logic [rcm_pkg::END_W-1:0]           w_end;
    logic [rcm_pkg::ROW_W-1:0]           w_rel;
    logic                                w_ceil;
    logic                                w_flr;

    assign w_adv_b = !r_b_vld || i_ready;
    assign w_adv_a = !r_a_vld || w_adv_b;
    assign o_ready = w_adv_a;
    assign o_valid = r_b_vld;
    assign o_cls   = r_cls;

    // stage A: slice start and clip on the top edge
    always_comb begin
        w_hq    = (i_pix.wall_height == '0) ? rcm_pkg::HQ_W'(1) : i_pix.wall_height;
        w_scr_q = rcm_pkg::HQ_W'(i_cfg.scr_h) << rcm_pkg::FRAC_W;
        w_diff  = w_scr_q - w_hq;
        w_over  = w_hq - w_scr_q;
        n_geo.column = i_pix.column;
        n_geo.row    = i_pix.row;
        n_geo.hq     = w_hq;
        n_geo.start  = (w_hq < w_scr_q) ?
                       w_diff[rcm_pkg::SCRQ_W-1:rcm_pkg::FRAC_W+1] : '0;
        n_geo.hint   = w_hq[rcm_pkg::HQ_W-1:rcm_pkg::FRAC_W];
        n_geo.clip2  = (w_hq > w_scr_q) ? w_over : '0;
        n_geo.tsel   = i_pix.tsel;
        n_geo.boff   = i_pix.boff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv_a) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a && i_valid) begin
            r_geo <= n_geo;
        end
    end

    // stage B: classify the row
    always_comb begin
        w_end  = rcm_pkg::END_W'(r_geo.hint) + rcm_pkg::END_W'(r_geo.start);
        w_ceil = r_geo.row < r_geo.start;
        w_flr  = rcm_pkg::END_W'(r_geo.row) >= w_end;
        w_rel  = r_geo.row - r_geo.start;
        n_cls.column = r_geo.column;
        n_cls.row    = r_geo.row;
        n_cls.hq     = r_geo.hq;
        n_cls.pos    = (rcm_pkg::POS_W'(w_rel) << (rcm_pkg::FRAC_W + 1))
                       + rcm_pkg::POS_W'(r_geo.clip2);
        n_cls.src    = w_ceil ? rcm_pkg::SRC_CEIL :
                       (w_flr ? rcm_pkg::SRC_FLOOR : rcm_pkg::SRC_WALL);
        n_cls.tsel   = r_geo.tsel;
        n_cls.boff   = r_geo.boff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_adv_b) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_b && r_a_vld) begin
            r_cls <= n_cls;
        end
    end

endmodule

// ----- hw/rtl/rcm_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_scale
// Two pipeline stages: the products (texel row dividend, texel column,
// framebuffer offset), then column saturation and flat color selection.
// ----------------------------------------------------------------------------
module rcm_scale (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rcm_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  rcm_pkg::t_cls  i_cls,
    output logic           o_valid,
    input  logic           i_ready,
    output rcm_pkg::t_dvin o_dv
);

    logic                          r_c_vld;
    rcm_pkg::t_prod                r_prod;
    rcm_pkg::t_prod                n_prod;
    logic                          r_d_vld;
    rcm_pkg::t_dvin                r_dv;
    rcm_pkg::t_dvin                n_dv;
    logic                          w_adv_c;
    logic                          w_adv_d;
    logic [rcm_pkg::DIM_W-1:0]     w_tw;
    logic [rcm_pkg::DIM_W-1:0]     w_th;
    logic [rcm_pkg::DIM_W-1:0]     w_tw_m1;
    logic [rcm_pkg::DIM_W-1:0]     w_tcol_sat;
    logic [rcm_pkg::FACT_W-1:0]    w_fact;
    logic [rcm_pkg::PROD_W-1:0]    w_row_bytes;

    assign w_adv_d = !r_d_vld || i_ready;
    assign w_adv_c = !r_c_vld || w_adv_d;
    assign o_ready = w_adv_c;
    assign o_valid = r_d_vld;
    assign o_dv    = r_dv;

    assign w_tw    = rcm_pkg::eff_dim(i_cfg.tex_w);
    assign w_th    = rcm_pkg::eff_dim(i_cfg.tex_h);
    assign w_tw_m1 = w_tw - rcm_pkg::DIM_W'(1);

    // stage C: multiplies
    always_comb begin
        w_fact      = rcm_pkg::FACT_W'(w_tw / rcm_pkg::BLOCK);
        w_row_bytes = rcm_pkg::PROD_W'(i_cls.row) * rcm_pkg::PROD_W'(i_cfg.line_len);
        n_prod.num  = rcm_pkg::NUM_W'(w_th) * rcm_pkg::NUM_W'(i_cls.pos);
        n_prod.hq   = i_cls.hq;
        n_prod.src  = i_cls.src;
        n_prod.tsel = i_cls.tsel;
        n_prod.tcol_raw = rcm_pkg::TCOLR_W'(i_cls.boff) * rcm_pkg::TCOLR_W'(w_fact);
        n_prod.poff = rcm_pkg::OFF_W'(w_row_bytes)
                      + rcm_pkg::OFF_W'(rcm_pkg::OFF_W'(i_cls.column)
                                        * rcm_pkg::OFF_W'(rcm_pkg::BYTES_PER_PIXEL));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_adv_c) begin
            r_c_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_c && i_valid) begin
            r_prod <= n_prod;
        end
    end

    // stage D: clamp column, pick color, set up the divisor
    always_comb begin
        w_tcol_sat = (r_prod.tcol_raw > rcm_pkg::TCOLR_W'(w_tw_m1)) ?
                     w_tw_m1 : r_prod.tcol_raw[rcm_pkg::DIM_W-1:0];
        n_dv.num       = r_prod.num;
        n_dv.den       = {r_prod.hq, 1'b0};
        n_dv.side.src  = r_prod.src;
        n_dv.side.tidx = r_prod.tsel;
        n_dv.side.poff = r_prod.poff;
        n_dv.side.tcol = (r_prod.src == rcm_pkg::SRC_WALL) ?
                         w_tcol_sat[rcm_pkg::TEX_W-1:0] : '0;
        case (r_prod.src)
            rcm_pkg::SRC_CEIL:  n_dv.side.flat = i_cfg.ceil_color;
            rcm_pkg::SRC_FLOOR: n_dv.side.flat = i_cfg.floor_color;
            default:            n_dv.side.flat = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_adv_d) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_d && r_c_vld) begin
            r_dv <= n_dv;
        end
    end

endmodule

// ----- hw/rtl/rcm_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_divider
// Restoring divider, one quotient bit per pipeline stage, followed by the
// output register that clamps the texel row and forms the result.
// ----------------------------------------------------------------------------
module rcm_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [rcm_pkg::DIM_W-1:0] i_tex_h,
    input  logic           i_valid,
    output logic           o_ready,
    input  rcm_pkg::t_dvin i_dv,
    output logic           o_valid,
    input  logic           i_ready,
    output rcm_pkg::t_res  o_res
);

    localparam int STEPS = rcm_pkg::QUO_W;

    logic [STEPS-1:0]              r_vld;
    rcm_pkg::t_dstep               r_stage [STEPS];
    rcm_pkg::t_dstep               w_src   [STEPS];
    logic [STEPS-1:0]              w_src_vld;
    logic [STEPS:0]                w_adv;
    logic                          r_out_vld;
    rcm_pkg::t_res                 r_res;
    rcm_pkg::t_res                 n_res;
    rcm_pkg::t_dstep               w_last;
    logic [rcm_pkg::DIM_W-1:0]     w_th_m1;
    logic [rcm_pkg::DIM_W-1:0]     w_trow_sat;

    assign w_adv[STEPS] = !r_out_vld || i_ready;
    assign o_ready      = w_adv[0];
    assign o_valid      = r_out_vld;
    assign o_res        = r_res;

    assign w_src[0].rem  = i_dv.num;
    assign w_src[0].quo  = '0;
    assign w_src[0].den  = i_dv.den;
    assign w_src[0].side = i_dv.side;
    assign w_src_vld[0]  = i_valid;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int SH = STEPS - 1 - k;

        rcm_pkg::t_dstep                n_stage;
        logic [rcm_pkg::NUM_W:0]        w_trial;

        if (k > 0) begin : g_link
            assign w_src[k]     = r_stage[k-1];
            assign w_src_vld[k] = r_vld[k-1];
        end

        assign w_adv[k] = !r_vld[k] || w_adv[k+1];

        // subtract the divisor shifted to this quotient bit, keep if no borrow
        always_comb begin
            w_trial = {1'b0, w_src[k].rem}
                      - ((rcm_pkg::NUM_W+1)'(w_src[k].den) << SH);
            n_stage = w_src[k];
            if (!w_trial[rcm_pkg::NUM_W]) begin
                n_stage.rem     = w_trial[rcm_pkg::NUM_W-1:0];
                n_stage.quo[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv[k]) begin
                r_vld[k] <= w_src_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k] && w_src_vld[k]) begin
                r_stage[k] <= n_stage;
            end
        end
    end

    assign w_last  = r_stage[STEPS-1];
    assign w_th_m1 = rcm_pkg::eff_dim(i_tex_h) - rcm_pkg::DIM_W'(1);

    always_comb begin
        w_trow_sat = (w_last.quo > rcm_pkg::QUO_W'(w_th_m1)) ?
                     w_th_m1 : w_last.quo[rcm_pkg::DIM_W-1:0];
        n_res.src  = w_last.side.src;
        n_res.flat = w_last.side.flat;
        n_res.tidx = w_last.side.tidx;
        n_res.tcol = w_last.side.tcol;
        n_res.poff = w_last.side.poff;
        n_res.trow = (w_last.side.src == rcm_pkg::SRC_WALL) ?
                     w_trow_sat[rcm_pkg::TEX_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv[STEPS]) begin
            r_out_vld <= r_vld[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[STEPS] && r_vld[STEPS-1]) begin
            r_res <= n_res;
        end
    end

endmodule

// ----- hw/rtl/raycast_column_texel_mapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_column_texel_mapper
// Maps one screen pixel of a raycast wall column to ceiling, floor or a
// wall texel, and gives its framebuffer byte offset.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel request per transfer; m_axis returns one result
//   per request, in order. m_axis_tuser holds the pixel source (ceiling,
//   wall, floor). Colors, screen height, texture size and line length sit
//   in APB registers at byte addresses 0x00..0x14; write them only while no
//   request is in flight.
//   Requests pass through 19 register stages: two classify stages, two
//   multiply/select stages, 14 divider stages (one texel row quotient bit
//   each) and the output register.
//   Throughput is one request per cycle while m_axis_tready does not stall
//   the pipe. Every stage holds its own valid bit and fills bubbles, so
//   s_axis_tready stays high while the pipe has room even if m_axis_tready
//   is low; a stalled result holds on m_axis.
//   Synchronous reset empties the pipe and loads the register defaults
//   (480 rows, 64x64 textures, 2560 bytes per line, black colors).
// ----------------------------------------------------------------------------
module raycast_column_texel_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rcm_pkg::ADDR_W-1:0]   paddr,
    input  logic [rcm_pkg::APB_W-1:0]    pwdata,
    output logic [rcm_pkg::APB_W-1:0]    prdata,
    output logic                         pready,
    // pixel requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // column[11:0], row[23:12], wall_height[47:24], texture_select[49:48],
    // block_offset[57:50], zero[63:58]
    input  logic [63:0] s_axis_tdata,
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // flat_color[31:0], texture_index[33:32], texel_column[45:34],
    // texel_row[57:46], pixel_offset[89:58], zero[95:90]
    output logic [95:0] m_axis_tdata,
    // source[1:0]
    output logic [1:0]  m_axis_tuser
);

    logic [rcm_pkg::COLOR_W-1:0]   r_ceil_color;
    logic [rcm_pkg::COLOR_W-1:0]   r_floor_color;
    logic [rcm_pkg::DIM_W-1:0]     r_scr_h;
    logic [rcm_pkg::DIM_W-1:0]     r_tex_w;
    logic [rcm_pkg::DIM_W-1:0]     r_tex_h;
    logic [rcm_pkg::LL_W-1:0]      r_line_len;
    logic                          w_wr;
    logic [rcm_pkg::REG_IDX_W-1:0] w_idx;
    rcm_pkg::t_cfg                 w_cfg;
    rcm_pkg::t_pix                 w_pix;
    logic                          w_cls_vld;
    logic                          w_cls_rdy;
    rcm_pkg::t_cls                 w_cls;
    logic                          w_dv_vld;
    logic                          w_dv_rdy;
    rcm_pkg::t_dvin                w_dv;
    rcm_pkg::t_res                 w_res;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[rcm_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceil_color  <= '0;
            r_floor_color <= '0;
            r_scr_h       <= rcm_pkg::SCR_H_RST;
            r_tex_w       <= rcm_pkg::TEX_W_RST;
            r_tex_h       <= rcm_pkg::TEX_H_RST;
            r_line_len    <= rcm_pkg::LINE_LEN_RST;
        end else if (w_wr) begin
            case (w_idx)
                rcm_pkg::REG_CEIL_COLOR:  r_ceil_color  <= pwdata;
                rcm_pkg::REG_FLOOR_COLOR: r_floor_color <= pwdata;
                rcm_pkg::REG_SCR_H:       r_scr_h       <= pwdata[rcm_pkg::DIM_W-1:0];
                rcm_pkg::REG_TEX_W:       r_tex_w       <= pwdata[rcm_pkg::DIM_W-1:0];
                rcm_pkg::REG_TEX_H:       r_tex_h       <= pwdata[rcm_pkg::DIM_W-1:0];
                rcm_pkg::REG_LINE_LEN:    r_line_len    <= pwdata[rcm_pkg::LL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            rcm_pkg::REG_CEIL_COLOR:  prdata = r_ceil_color;
            rcm_pkg::REG_FLOOR_COLOR: prdata = r_floor_color;
            rcm_pkg::REG_SCR_H:       prdata = rcm_pkg::APB_W'(r_scr_h);
            rcm_pkg::REG_TEX_W:       prdata = rcm_pkg::APB_W'(r_tex_w);
            rcm_pkg::REG_TEX_H:       prdata = rcm_pkg::APB_W'(r_tex_h);
            rcm_pkg::REG_LINE_LEN:    prdata = rcm_pkg::APB_W'(r_line_len);
            default:                  prdata = '0;
        endcase
    end

    assign w_cfg.ceil_color  = r_ceil_color;
    assign w_cfg.floor_color = r_floor_color;
    assign w_cfg.scr_h       = r_scr_h;
    assign w_cfg.tex_w       = r_tex_w;
    assign w_cfg.tex_h       = r_tex_h;
    assign w_cfg.line_len    = r_line_len;

    assign w_pix.column      = s_axis_tdata[11:0];
    assign w_pix.row         = s_axis_tdata[23:12];
    assign w_pix.wall_height = s_axis_tdata[47:24];
    assign w_pix.tsel        = s_axis_tdata[49:48];
    assign w_pix.boff        = s_axis_tdata[57:50];

    rcm_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pix   (w_pix),
        .o_valid (w_cls_vld),
        .i_ready (w_cls_rdy),
        .o_cls   (w_cls)
    );

    rcm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_cls_vld),
        .o_ready (w_cls_rdy),
        .i_cls   (w_cls),
        .o_valid (w_dv_vld),
        .i_ready (w_dv_rdy),
        .o_dv    (w_dv)
    );

    rcm_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tex_h (r_tex_h),
        .i_valid (w_dv_vld),
        .o_ready (w_dv_rdy),
        .i_dv    (w_dv),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res)
    );

    assign m_axis_tuser = w_res.src;
    assign m_axis_tdata = {6'b0, w_res.poff, w_res.trow, w_res.tcol,
                           w_res.tidx, w_res.flat};

endmodule

// ----- hw/rtl/rcm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_checker
// Port-level checks of the raycast column texel mapper, bound to the top.
// ----------------------------------------------------------------------------
module rcm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("m_axis result changed while stalled");

    // wall pixels carry no flat color
    a_wall_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == rcm_pkg::SRC_WALL |->
            m_axis_tdata[31:0] == '0)
        else $error("wall pixel with nonzero flat color");

    // ceiling and floor pixels carry no texel coordinates
    a_flat_texel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != rcm_pkg::SRC_WALL |->
            m_axis_tdata[57:34] == '0)
        else $error("flat pixel with texel coordinates");

    // the pipe is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind raycast_column_texel_mapper rcm_checker u_rcm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
